FILE: hdl/ppe_pkg.sv
// package: widths, register indexes and shared types of the projection error core
package ppe_pkg;

  localparam int PointW  = 20;
  localparam int PixW    = 24;
  localparam int RotW    = 16;
  localparam int DiffW   = 21;
  localparam int CamW    = 39;
  localparam int NumW    = 63;
  localparam int QuoW    = 40;
  localparam int OutW    = 32;
  localparam int ErrW    = 48;
  localparam int AddrW   = 6;
  localparam int DataW   = 64;

  localparam logic [2:0] RegFocal  = 3'd0;
  localparam logic [2:0] RegCx     = 3'd1;
  localparam logic [2:0] RegCy     = 3'd2;
  localparam logic [2:0] RegTrans  = 3'd3;
  localparam logic [2:0] RegRot0   = 3'd4;
  localparam logic [2:0] RegRot1   = 3'd5;
  localparam logic [2:0] RegRot2   = 3'd6;

  typedef struct packed {
    logic [23:0] focal;
    logic signed [PixW-1:0] cx;
    logic signed [PixW-1:0] cy;
    logic [59:0] trans;
    logic [47:0] rot0;
    logic [47:0] rot1;
    logic [47:0] rot2;
  } cfg_t;

  typedef struct packed {
    logic signed [PointW-1:0] point_x;
    logic signed [PointW-1:0] point_y;
    logic signed [PointW-1:0] point_z;
    logic signed [PixW-1:0] observed_u;
    logic signed [PixW-1:0] observed_v;
  } in_beat_t;

  typedef struct packed {
    logic signed [OutW-1:0] proj_u;
    logic signed [OutW-1:0] proj_v;
    logic [ErrW-1:0] sq_error;
    logic depth_zero;
  } out_beat_t;

endpackage

FILE: hdl/ppe_stream_if.sv
// stream interfaces for point beats and result beats
interface ppe_in_if;
  import ppe_pkg::*;
  logic valid;
  logic ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppe_out_if;
  import ppe_pkg::*;
  logic valid;
  logic ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/ppe_regs.sv
// apb register file for camera parameters
module ppe_regs import ppe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic pready,
  output cfg_t cfg
);
  logic wr;
  logic [2:0] idx;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal <= '0;
      cfg.cx <= '0;
      cfg.cy <= '0;
      cfg.trans <= '0;
      cfg.rot0 <= 48'd16384;
      cfg.rot1 <= 48'd16384 << 16;
      cfg.rot2 <= 48'd16384 << 32;
    end else if (wr && paddr[2:0] == 3'd0) begin
      case (idx)
        RegFocal: cfg.focal <= pwdata[23:0];
        RegCx:    cfg.cx <= pwdata[23:0];
        RegCy:    cfg.cy <= pwdata[23:0];
        RegTrans: cfg.trans <= pwdata[59:0];
        RegRot0:  cfg.rot0 <= pwdata[47:0];
        RegRot1:  cfg.rot1 <= pwdata[47:0];
        RegRot2:  cfg.rot2 <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegFocal: prdata = {40'd0, cfg.focal};
      RegCx:    prdata = {40'd0, cfg.cx};
      RegCy:    prdata = {40'd0, cfg.cy};
      RegTrans: prdata = {4'd0, cfg.trans};
      RegRot0:  prdata = {16'd0, cfg.rot0};
      RegRot1:  prdata = {16'd0, cfg.rot1};
      RegRot2:  prdata = {16'd0, cfg.rot2};
      default:  prdata = '0;
    endcase
  end
endmodule

FILE: hdl/ppe_divider.sv
// pipelined restoring divider, one quotient bit per stage, carries a side payload
module ppe_divider import ppe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [NumW-1:0] num,
  input  logic [CamW-1:0] den,
  input  logic [PixW+1:0] side_in,
  output logic out_valid,
  output logic [QuoW-1:0] quo,
  output logic [PixW+1:0] side_out
);
  localparam int Steps = QuoW;
  logic [Steps:0] v;
  logic [Steps:0] o;
  logic [NumW-1:0] n [Steps+1];
  logic [CamW-1:0] d [Steps+1];
  logic [CamW:0] r [Steps+1];
  logic [QuoW-1:0] q [Steps+1];
  logic [PixW+1:0] s [Steps+1];

  // upper numerator bits seed the remainder, a quotient past QuoW bits saturates
  assign v[0] = in_valid;
  assign o[0] = CamW'(num[NumW-1:QuoW]) >= den;
  assign n[0] = num;
  assign d[0] = den;
  assign r[0] = (CamW+1)'(num[NumW-1:QuoW]);
  assign q[0] = '0;
  assign s[0] = side_in;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [CamW+1:0] trial;
    logic take;
    logic [CamW:0] shifted;
    assign shifted = {r[k][CamW-1:0], n[k][QuoW-1-k]};
    assign trial = {1'b0, shifted} - {2'b0, d[k]};
    assign take = !trial[CamW+1];
    always_ff @(posedge clk) begin
      if (rst) v[k+1] <= 1'b0;
      else if (en) v[k+1] <= v[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        o[k+1] <= o[k];
        n[k+1] <= n[k];
        d[k+1] <= d[k];
        r[k+1] <= take ? trial[CamW:0] : shifted;
        q[k+1] <= {q[k][QuoW-2:0], take};
        s[k+1] <= s[k];
      end
    end
  end

  assign out_valid = v[Steps];
  assign quo = o[Steps] ? {QuoW{1'b1}} : q[Steps];
  assign side_out = s[Steps];
endmodule

FILE: hdl/pinhole_projection_error_core.sv
// top level: pinhole reprojection error pipeline
// One point beat enters per cycle and a result leaves per cycle while the
// output is not stalled; between an accepted point beat and its result lie 50 register
// stages, most of them a 40-stage quotient pipeline that resolves one bit per
// stage for each of the two image axes. The whole
// pipeline advances together and holds when the output register is full
// and not taken. Camera parameters are to be written over the apb port only while idle; the core does not enforce it.
module pinhole_projection_error_core import ppe_pkg::*; (
  input  logic clk,
  input  logic rst,
  ppe_in_if.sink   in_ch,
  ppe_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic pready
);
  cfg_t cfg;
  logic en;

  ppe_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: translate
  logic v1;
  logic signed [DiffW-1:0] d1 [3];
  logic signed [PixW-1:0] ou1, ov1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= DiffW'(in_ch.data.point_x) - DiffW'($signed(cfg.trans[19:0]));
      d1[1] <= DiffW'(in_ch.data.point_y) - DiffW'($signed(cfg.trans[39:20]));
      d1[2] <= DiffW'(in_ch.data.point_z) - DiffW'($signed(cfg.trans[59:40]));
      ou1 <= in_ch.data.observed_u;
      ov1 <= in_ch.data.observed_v;
    end
  end

  // stage 2: products
  logic v2;
  logic signed [DiffW+RotW-1:0] p2 [3][3];
  logic signed [PixW-1:0] ou2, ov2;
  logic [47:0] rows [3];
  assign rows[0] = cfg.rot0;
  assign rows[1] = cfg.rot1;
  assign rows[2] = cfg.rot2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) p2[i][j] <= $signed(rows[i][16*j +: 16]) * d1[j];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ou2 <= ou1;
      ov2 <= ov1;
    end
  end

  // stage 3: sums
  logic v3;
  logic signed [CamW-1:0] c3 [3];
  logic signed [PixW-1:0] ou3, ov3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  for (genvar i = 0; i < 3; i++) begin : g_sum
    always_ff @(posedge clk) begin
      if (en) c3[i] <= CamW'(p2[i][0]) + CamW'(p2[i][1]) + CamW'(p2[i][2]);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ou3 <= ou2;
      ov3 <= ov2;
    end
  end

  // stage 4: magnitudes and quotient signs; stage 5: focal products, split into 24x20 and 24x19 partial products
  logic v4;
  logic signed [CamW-1:0] cz4;
  logic [CamW-1:0] mx4, my4;
  logic sx4, sy4;
  logic signed [PixW-1:0] ou4, ov4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mx4 <= c3[0][CamW-1] ? CamW'(-c3[0]) : CamW'(c3[0]);
      my4 <= c3[1][CamW-1] ? CamW'(-c3[1]) : CamW'(c3[1]);
      sx4 <= c3[0][CamW-1] ^ c3[2][CamW-1];
      sy4 <= c3[1][CamW-1] ^ c3[2][CamW-1];
      cz4 <= c3[2];
      ou4 <= ou3;
      ov4 <= ov3;
    end
  end

  logic v5;
  logic [43:0] xl5, xh5, yl5, yh5;
  logic sx5, sy5;
  logic signed [CamW-1:0] cz5;
  logic signed [PixW-1:0] ou5, ov5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      xl5 <= 44'(cfg.focal * mx4[19:0]);
      xh5 <= 44'(cfg.focal * mx4[CamW-1:20]);
      yl5 <= 44'(cfg.focal * my4[19:0]);
      yh5 <= 44'(cfg.focal * my4[CamW-1:20]);
      sx5 <= sx4;
      sy5 <= sy4;
      cz5 <= cz4;
      ou5 <= ou4;
      ov5 <= ov4;
    end
  end

  // stage 6: numerators with rounding bias
  logic v6;
  logic [NumW-1:0] nx6, ny6;
  logic [CamW-1:0] az6;
  logic zero6, sx6, sy6;
  logic signed [PixW-1:0] ou6, ov6;
  logic [CamW-1:0] az5;
  assign az5 = cz5[CamW-1] ? CamW'(-cz5) : CamW'(cz5);
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nx6 <= NumW'(xl5) + (NumW'(xh5) << 20) + NumW'(az5 >> 1);
      ny6 <= NumW'(yl5) + (NumW'(yh5) << 20) + NumW'(az5 >> 1);
      az6 <= (az5 == '0) ? CamW'(1) : az5;
      zero6 <= (az5 == '0);
      sx6 <= sx5;
      sy6 <= sy5;
      ou6 <= ou5;
      ov6 <= ov5;
    end
  end

  // stages 7..46: two dividers in lock step
  logic dvx, dvy;
  logic [QuoW-1:0] qx, qy;
  logic [PixW+1:0] sidex, sidey;
  ppe_divider u_divx (
    .clk, .rst, .en, .in_valid(v6), .num(nx6), .den(az6),
    .side_in({zero6, sx6, ou6}), .out_valid(dvx), .quo(qx), .side_out(sidex)
  );
  ppe_divider u_divy (
    .clk, .rst, .en, .in_valid(v6), .num(ny6), .den(az6),
    .side_in({1'b0, sy6, ov6}), .out_valid(dvy), .quo(qy), .side_out(sidey)
  );

  // stage 47: subtract from center and saturate
  logic v7, zero7;
  logic signed [OutW-1:0] pu7, pv7;
  logic signed [PixW-1:0] ou7, ov7;
  logic signed [QuoW+1:0] tu, tv;
  always_comb begin
    tu = sidex[PixW] ? (QuoW+2)'($signed(cfg.cx)) + $signed({2'b0, qx})
                     : (QuoW+2)'($signed(cfg.cx)) - $signed({2'b0, qx});
    tv = sidey[PixW] ? (QuoW+2)'($signed(cfg.cy)) + $signed({2'b0, qy})
                     : (QuoW+2)'($signed(cfg.cy)) - $signed({2'b0, qy});
  end
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= dvx;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      zero7 <= sidex[PixW+1];
      pu7 <= (tu > 42'sd2147483647) ? 32'h7fffffff :
             (tu < -42'sd2147483648) ? 32'h80000000 : tu[OutW-1:0];
      pv7 <= (tv > 42'sd2147483647) ? 32'h7fffffff :
             (tv < -42'sd2147483648) ? 32'h80000000 : tv[OutW-1:0];
      ou7 <= sidex[PixW-1:0];
      ov7 <= sidey[PixW-1:0];
    end
  end

  // stage 48: differences
  logic v8, zero8, bu8, bv8;
  logic [23:0] mu8, mv8;
  logic signed [OutW-1:0] pu8, pv8;
  logic signed [OutW:0] du, dv;
  logic [OutW:0] adu, adv;
  assign du = (OutW+1)'(pu7) - (OutW+1)'(ou7);
  assign dv = (OutW+1)'(pv7) - (OutW+1)'(ov7);
  assign adu = du[OutW] ? (OutW+1)'(-du) : du;
  assign adv = dv[OutW] ? (OutW+1)'(-dv) : dv;
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      zero8 <= zero7;
      pu8 <= pu7;
      pv8 <= pv7;
      mu8 <= adu[23:0];
      mv8 <= adv[23:0];
      bu8 <= adu[OutW:24] != '0;
      bv8 <= adv[OutW:24] != '0;
    end
  end

  // stage 49: squares
  logic v9, zero9, big9;
  logic [ErrW-1:0] su9, sv9;
  logic signed [OutW-1:0] pu9, pv9;
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      zero9 <= zero8;
      pu9 <= pu8;
      pv9 <= pv8;
      su9 <= mu8 * mu8;
      sv9 <= mv8 * mv8;
      big9 <= bu8 || bv8;
    end
  end

  // stage 50: sum and output register
  logic [ErrW:0] es;
  assign es = {1'b0, su9} + {1'b0, sv9};
  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (en) out_ch.valid <= v9;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.data.depth_zero <= zero9;
      out_ch.data.proj_u <= zero9 ? 32'h7fffffff : pu9;
      out_ch.data.proj_v <= zero9 ? 32'h7fffffff : pv9;
      out_ch.data.sq_error <= (zero9 || big9 || es[ErrW]) ? {ErrW{1'b1}} : es[ErrW-1:0];
    end
  end

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst) dvx == dvy)
    else $error("divider lanes out of step");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped under stall");
  a_zero_sat: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.depth_zero |-> out_ch.data.sq_error == {ErrW{1'b1}})
    else $error("zero depth not saturated");
endmodule

FILE: tb/pinhole_projection_error_core_tb.sv
// testbench: random and directed projection beats checked against a fixed point pinhole model
`timescale 1ns / 100ps

import ppe_pkg::*;

class proj_scoreboard;

  logic [23:0] focal;
  logic [23:0] cx;
  logic [23:0] cy;
  logic [59:0] trans;
  logic [47:0] rot [3];
  out_beat_t pending [$];
  int errors;
  int results;
  int zero_depth_seen;

  function new();
    focal = '0;
    cx = '0;
    cy = '0;
    trans = '0;
    rot[0] = 48'd16384;
    rot[1] = 48'd16384 << 16;
    rot[2] = 48'd16384 << 32;
    errors = 0;
    results = 0;
    zero_depth_seen = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      RegFocal: focal = val[23:0];
      RegCx:    cx = val[23:0];
      RegCy:    cy = val[23:0];
      RegTrans: trans = val[59:0];
      RegRot0:  rot[0] = val[47:0];
      RegRot1:  rot[1] = val[47:0];
      RegRot2:  rot[2] = val[47:0];
      default: ;
    endcase
  endfunction

  function longint round_div(longint n, longint d);
    longint an;
    longint ad;
    longint q;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q = (an + ad / 2) / ad;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function logic [48:0] square_sat(longint d);
    longint m;
    m = (d < 0) ? -d : d;
    if (m >= (64'sd1 << 24)) return 49'h1_0000_0000_0000;
    return 49'(m * m);
  endfunction

  function void note_point(in_beat_t p);
    longint pt [3];
    longint diff [3];
    longint cam [3];
    longint pu;
    longint pv;
    logic [49:0] err;
    out_beat_t r;
    pt[0] = longint'(p.point_x);
    pt[1] = longint'(p.point_y);
    pt[2] = longint'(p.point_z);
    for (int i = 0; i < 3; i++)
      diff[i] = pt[i] - longint'($signed(trans[20*i +: 20]));
    for (int i = 0; i < 3; i++) begin
      cam[i] = 0;
      for (int j = 0; j < 3; j++)
        cam[i] += longint'($signed(rot[i][16*j +: 16])) * diff[j];
    end
    if (cam[2] == 0) begin
      r.proj_u = 32'h7FFF_FFFF;
      r.proj_v = 32'h7FFF_FFFF;
      r.sq_error = '1;
      r.depth_zero = 1'b1;
    end else begin
      pu = clamp32(longint'($signed(cx)) - round_div(longint'(focal) * cam[0], cam[2]));
      pv = clamp32(longint'($signed(cy)) - round_div(longint'(focal) * cam[1], cam[2]));
      err = 50'(square_sat(pu - longint'(p.observed_u))) +
            50'(square_sat(pv - longint'(p.observed_v)));
      if (err[49:48] != 2'b00) err = {2'b00, {48{1'b1}}};
      r.proj_u = pu[31:0];
      r.proj_v = pv[31:0];
      r.sq_error = err[47:0];
      r.depth_zero = 1'b0;
    end
    pending.push_back(r);
  endfunction

  function void check_result(out_beat_t got);
    out_beat_t exp_r;
    results++;
    if (pending.size() == 0) begin
      $error("result beat with nothing expected");
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (exp_r.depth_zero) zero_depth_seen++;
    if (got.proj_u !== exp_r.proj_u) begin
      $error("proj_u expected %0d got %0d", exp_r.proj_u, got.proj_u);
      errors++;
    end
    if (got.proj_v !== exp_r.proj_v) begin
      $error("proj_v expected %0d got %0d", exp_r.proj_v, got.proj_v);
      errors++;
    end
    if (got.sq_error !== exp_r.sq_error) begin
      $error("sq_error expected %0h got %0h", exp_r.sq_error, got.sq_error);
      errors++;
    end
    if (got.depth_zero !== exp_r.depth_zero) begin
      $error("depth_zero expected %0b got %0b", exp_r.depth_zero, got.depth_zero);
      errors++;
    end
  endfunction
endclass

module pinhole_projection_error_core_tb;
  import ppe_pkg::*;

  localparam int Latency = 50;
  localparam int CycleLimit = 400000;
  localparam logic [47:0] Ident0 = 48'd16384;
  localparam logic [47:0] Ident1 = 48'd16384 << 16;
  localparam logic [47:0] Ident2 = 48'd16384 << 32;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;
  logic gaps_on;
  int cycles = 0;
  int sent;

  ppe_in_if in_ch ();
  ppe_out_if out_ch ();
  proj_scoreboard sb;

  pinhole_projection_error_core uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) sb.note_point(in_ch.data);
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  // sink side stalls
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = AddrW'(8 * idx);
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_point(in_beat_t p);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = p;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
    sent++;
  endtask

  function automatic in_beat_t make_point(int px, int py, int pz, int ou, int ov);
    in_beat_t p;
    p.point_x = px[19:0];
    p.point_y = py[19:0];
    p.point_z = pz[19:0];
    p.observed_u = ou[23:0];
    p.observed_v = ov[23:0];
    return p;
  endfunction

  function automatic in_beat_t rand_point();
    in_beat_t p;
    p.point_x = 20'($urandom);
    p.point_y = 20'($urandom);
    p.point_z = 20'($urandom);
    p.observed_u = 24'($urandom);
    p.observed_v = 24'($urandom);
    return p;
  endfunction

  function automatic logic [47:0] rand_row(int diag);
    logic [47:0] r;
    r = 48'({$urandom, $urandom});
    if ($urandom_range(0, 1)) begin
      r = {3{16'($signed($urandom_range(0, 2047)) - 16'sd1024)}};
      r[16*diag +: 16] = 16'($urandom_range(12000, 16384));
    end
    return r;
  endfunction

  task automatic random_phase(int n, bit identity);
    logic [59:0] t;
    in_beat_t p;
    drain();
    case ($urandom_range(0, 3))
      0: write_reg(RegFocal, 64'hFF_FFFF);
      1: write_reg(RegFocal, 64'd0);
      default: write_reg(RegFocal, 64'($urandom_range(256, 1 << 20)));
    endcase
    write_reg(RegCx, 64'($urandom));
    write_reg(RegCy, $urandom_range(0, 3) == 0 ? 64'h80_0000 : 64'($urandom_range(0, 65535)));
    t = 60'({$urandom, $urandom});
    write_reg(RegTrans, 64'(t));
    write_reg(RegRot0, identity ? 64'(Ident0) : 64'(rand_row(0)));
    write_reg(RegRot1, identity ? 64'(Ident1) : 64'(rand_row(1)));
    write_reg(RegRot2, identity ? 64'(Ident2) : 64'(rand_row(2)));
    for (int k = 0; k < n; k++) begin
      p = rand_point();
      if (identity && $urandom_range(0, 15) == 0) p.point_z = t[59:40];
      else if (identity && $urandom_range(0, 3) == 0)
        p.point_z = t[59:40] + 20'($signed($urandom_range(0, 16)) - 8);
      send_point(p);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    sent = 0;
    gaps_on = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: zero focal, identity rotation
    send_point(make_point(256, -256, 256, 0, 0));
    send_point(make_point(5, 5, 0, 0, 0));
    drain();
    write_reg(RegFocal, 64'd256 * 500);
    write_reg(RegCx, 64'd320 << 8);
    write_reg(RegCy, 64'd240 << 8);
    send_point(make_point(256, 512, 2560, 320 << 8, 240 << 8));
    send_point(make_point(256, 512, -2560, 0, 0));
    send_point(make_point(524287, 524287, 524287, 8388607, 8388607));
    send_point(make_point(-524288, -524288, -524288, -8388608, -8388608));
    send_point(make_point(524287, -524288, 1, -8388608, 8388607));
    send_point(make_point(-524288, 524287, -1, 8388607, -8388608));
    send_point(make_point(3, 3, 0, 0, 0));
    drain();
    write_reg(RegFocal, 64'hFF_FFFF);
    write_reg(RegCx, 64'h7F_FFFF);
    write_reg(RegCy, 64'h80_0000);
    write_reg(RegTrans, {4'd0, 20'd256, 20'hFFF00, 20'd1});
    send_point(make_point(1, -256, 256, 0, 0));
    send_point(make_point(524287, 524287, 257, -8388608, 8388607));
    send_point(make_point(-524288, -524288, 255, 8388607, -8388608));
    send_point(make_point(7, 7, 7, 0, 0));
    drain();
    write_reg(RegRot0, 64'hFFFF_7FFF_8000);
    write_reg(RegRot1, 64'h8000_8000_8000);
    write_reg(RegRot2, 64'h7FFF_7FFF_7FFF);
    send_point(make_point(524287, -524288, 524287, 100, -100));
    send_point(make_point(-524288, 524287, -524288, 0, 0));
    send_point(make_point(1, 0, 0, 0, 0));
    send_point(make_point(1, 1, 1, 0, 0));
    drain();
    write_reg(RegRot2, 64'd0);
    send_point(make_point(12345, -999, 4242, 0, 0));

    gaps_on = 1'b1;
    random_phase(300, 1'b1);
    random_phase(300, 1'b0);
    random_phase(300, 1'b1);
    random_phase(300, 1'b0);
    random_phase(250, 1'b1);
    gaps_on = 1'b0;
    random_phase(350, 1'b0);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    $display("covered %0d point beats, %0d results checked, %0d at zero depth",
      sent, sb.results, sb.zero_depth_seen);
    $display("camera settings cycled through extremes, identity and random rotations");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
